@@ rtl/core/fbp_pkg.sv @@
package fbp_pkg;

  typedef logic signed [15:0] flow_t;
  typedef logic        [15:0] gain_t;
  typedef logic        [7:0]  byte_t;

  // Register map, word index
  localparam logic REG_FLOW_GAIN = 1'b0;

  localparam gain_t GAIN_RESET = 16'd1536;

  // Root bits resolved by the square-root pipe, one per stage
  localparam int unsigned SQRT_STEPS = 16;

  // Upper bound on the root of h*h + v*v over the 16-bit signed range
  localparam logic [31:0] MAG_MAX = 32'd46341;

  // One beat travelling down the square-root pipe
  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [31:0] root;
    flow_t       h;
    flow_t       v;
  } sqrt_stage_t;

endpackage

@@ rtl/core/fbp_square.sv @@
module fbp_square (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  fbp_pkg::flow_t       h,
  input  fbp_pkg::flow_t       v,
  output fbp_pkg::sqrt_stage_t out
);
  import fbp_pkg::*;

  logic               sq_valid;
  logic signed [31:0] hh;
  logic signed [31:0] vv;
  flow_t              sq_h;
  flow_t              sq_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      out.valid <= 1'b0;
    end else if (en) begin
      sq_valid  <= in_valid;
      out.valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh   <= h * h;
      vv   <= v * v;
      sq_h <= h;
      sq_v <= v;
      // Both squares are at most 2^30, so the sum fits 32 bits unsigned
      out.rem  <= unsigned'(hh) + unsigned'(vv);
      out.root <= '0;
      out.h    <= sq_h;
      out.v    <= sq_v;
    end
  end

endmodule

@@ rtl/core/fbp_sqrt_stage.sv @@
module fbp_sqrt_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  fbp_pkg::sqrt_stage_t in,
  output fbp_pkg::sqrt_stage_t out
);
  import fbp_pkg::*;

  localparam logic [31:0] BIT = 32'd1 << (30 - 2 * STEP);

  logic [31:0] trial;
  logic        take;

  assign trial = in.root + BIT;
  assign take  = in.rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.rem  <= take ? in.rem - trial : in.rem;
      out.root <= take ? (in.root >> 1) + BIT : in.root >> 1;
      out.h    <= in.h;
      out.v    <= in.v;
    end
  end

endmodule

@@ rtl/core/fbp_scale.sv @@
module fbp_scale (
  input  logic                clk,
  input  logic                en,
  input  logic signed [16:0]  raw,
  input  fbp_pkg::gain_t      gain,
  output fbp_pkg::byte_t      byte_out
);
  import fbp_pkg::*;

  localparam logic signed [34:0] BIAS = 35'sd1 <<< 23;

  logic signed [33:0] product;
  logic signed [34:0] t;
  logic        [18:0] q;
  logic        [15:0] r;
  logic               up;
  logic        [19:0] q_round;

  assign product = raw * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (en) begin
      t <= 35'(product) + BIAS;
    end
  end

  assign q       = t[34:16];
  assign r       = t[15:0];
  assign up      = (r > 16'h8000) || ((r == 16'h8000) && q[0]);
  assign q_round = 20'(q) + 20'(up);

  always_ff @(posedge clk) begin
    if (en) begin
      if (t[34]) begin
        byte_out <= 8'd0;
      end else if (q_round > 20'd255) begin
        byte_out <= 8'd255;
      end else begin
        byte_out <= q_round[7:0];
      end
    end
  end

endmodule

@@ rtl/core/flow_to_bgr_pixel.sv @@
// Flow vector to color pixel.
// Input stream: one beat per pixel, tdata carries the horizontal and vertical
// flow as signed Q7.8 values. Output stream: one beat per pixel with blue
// (scaled magnitude), green (scaled vertical) and red (scaled horizontal),
// each the value times flow_gain plus 128, rounded to nearest even and
// clamped to 0..255.
// flow_gain (unsigned Q8.8) sits at byte address 0 of the APB port; write it
// only while no pixel is in flight.
// Throughput: one pixel per cycle while the output is not stalled. The pipe
// is made of the squaring and summing registers, sixteen square root
// stages (one root bit each), one multiply stage and one round stage.
// Reset: all valid bits clear, flow_gain returns to 6.0 (1536).
// Stall: the whole pipe holds while the output beat waits; s_tready drops
// in the same cycle, so nothing is dropped or repeated.
module flow_to_bgr_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [15:0] flow_horizontal, [31:16] flow_vertical
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [7:0] blue_byte, [15:8] green_byte, [23:16] red_byte
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbp_pkg::*;

  logic        en;
  gain_t       flow_gain;
  sqrt_stage_t stage [0:SQRT_STEPS];
  logic        mul_valid;
  byte_t       blue;
  byte_t       green;
  byte_t       red;

  // Advance the pipe whenever the output register is empty or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Configuration: word address decode, low byte bits ignored
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLOW_GAIN) ? {16'd0, flow_gain} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FLOW_GAIN)) begin
      flow_gain <= pwdata[15:0];
    end
  end

  // Squares and their sum
  fbp_square u_square (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid && s_tready),
    .h        (flow_t'(s_tdata[15:0])),
    .v        (flow_t'(s_tdata[31:16])),
    .out      (stage[0])
  );

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    fbp_sqrt_stage #(.STEP(k)) u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .in  (stage[k]),
      .out (stage[k+1])
    );
  end

  // Scale and round all three channels in parallel
  fbp_scale u_blue (
    .clk      (clk),
    .en       (en),
    .raw      ({1'b0, stage[SQRT_STEPS].root[15:0]}),
    .gain     (flow_gain),
    .byte_out (blue)
  );

  fbp_scale u_green (
    .clk      (clk),
    .en       (en),
    .raw      (17'(stage[SQRT_STEPS].v)),
    .gain     (flow_gain),
    .byte_out (green)
  );

  fbp_scale u_red (
    .clk      (clk),
    .en       (en),
    .raw      (17'(stage[SQRT_STEPS].h)),
    .gain     (flow_gain),
    .byte_out (red)
  );

  // Valid follows the two scale stages; the round stage is the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (en) begin
      mul_valid <= stage[SQRT_STEPS].valid;
      m_tvalid  <= mul_valid;
    end
  end

  assign m_tdata = {red, green, blue};

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A finished root never exceeds the largest possible magnitude
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    stage[SQRT_STEPS].valid |-> stage[SQRT_STEPS].root <= MAG_MAX)
    else $error("square root out of range");

  // Floor root leaves a remainder of at most twice the root
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    stage[SQRT_STEPS].valid |->
      {1'b0, stage[SQRT_STEPS].rem} <= {stage[SQRT_STEPS].root, 1'b0})
    else $error("square root remainder too large");

endmodule

@@ dv/flow_to_bgr_pixel_checker.sv @@
module flow_to_bgr_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned pixels_in_flight
);
  import fbp_pkg::*;

  localparam logic [2:0] GAIN_ADDR = {REG_FLOW_GAIN, 2'b00};
  localparam int unsigned MAX_REPORTS = 50;

  // Same layout as m_tdata: blue in the low byte.
  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
  } bgr_t;

  gain_t       gain_shadow;
  bgr_t        bgr_expected[$];
  int unsigned mismatches = 0;
  int unsigned queued = 0;
  int unsigned beats_out = 0;

  assign fail_count       = mismatches;
  assign pixels_in_flight = queued;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH at %0t, output beat %0d: %s got %0d, want %0d",
               $realtime, beats_out, what, got, want);
    mismatches++;
  endtask

  // Bitwise search for the largest root whose square fits.
  function automatic logic [15:0] mag_floor(input logic [31:0] sum_sq);
    logic [15:0] root;
    logic [15:0] trial;
    int          i;
    root = '0;
    for (i = 15; i >= 0; i--) begin
      trial = root | (16'd1 << i);
      if (32'(trial) * 32'(trial) <= sum_sq) root = trial;
    end
    return root;
  endfunction

  function automatic byte_t scale_to_byte(input logic signed [31:0] raw, input gain_t g);
    logic signed [63:0] raw64;
    logic signed [63:0] gain64;
    logic signed [63:0] acc;
    logic [47:0]        whole;
    logic [15:0]        frac;
    raw64  = raw;
    gain64 = {48'd0, g};
    acc    = raw64 * gain64 + 64'sd8388608;  // + 128.0 in Q.16
    if (acc < 0) return 8'd0;
    whole = acc[63:16];
    frac  = acc[15:0];
    if (frac > 16'h8000 || (frac == 16'h8000 && whole[0])) whole++;
    if (whole > 48'd255) return 8'hFF;
    return whole[7:0];
  endfunction

  function automatic bgr_t predict_pixel(input flow_t h, input flow_t v, input gain_t g);
    logic signed [31:0] h32;
    logic signed [31:0] v32;
    logic [31:0]        sum_sq;
    bgr_t               px;
    h32      = h;
    v32      = v;
    sum_sq   = h32 * h32 + v32 * v32;
    px.blue  = scale_to_byte($signed({16'd0, mag_floor(sum_sq)}), g);
    px.green = scale_to_byte(v32, g);
    px.red   = scale_to_byte(h32, g);
    return px;
  endfunction

  always @(posedge clk) begin
    bgr_t got;
    bgr_t want;
    if (rst) begin
      gain_shadow <= GAIN_RESET;
      bgr_expected.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (bgr_expected.size() == 0) begin
          report_mismatch("unexpected beat, tdata", m_tdata, 0);
        end else begin
          want = bgr_expected.pop_front();
          if (got.blue != want.blue)   report_mismatch("blue_byte", got.blue, want.blue);
          if (got.green != want.green) report_mismatch("green_byte", got.green, want.green);
          if (got.red != want.red)     report_mismatch("red_byte", got.red, want.red);
        end
        beats_out++;
      end
      if (s_tvalid && s_tready)
        bgr_expected.insert(bgr_expected.size(),
                            predict_pixel(s_tdata[15:0], s_tdata[31:16], gain_shadow));
      if (psel && penable && pready && paddr == GAIN_ADDR) begin
        if (pwrite) gain_shadow <= pwdata[15:0];
        else if (prdata != {16'd0, gain_shadow})
          report_mismatch("flow_gain readback", prdata, gain_shadow);
      end
    end
    queued = bgr_expected.size();
  end

endmodule

@@ dv/flow_to_bgr_pixel_test.sv @@
module flow_to_bgr_pixel_test;
  import fbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PIPE_LATENCY    = 20;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PIXELS_PER_PHASE = 165;
  localparam logic [2:0]  GAIN_ADDR       = {REG_FLOW_GAIN, 2'b00};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // [15:0] flow_horizontal, [31:16] flow_vertical
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] blue_byte, [15:8] green_byte, [23:16] red_byte
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pixels_in_flight;
  int unsigned cycle_count = 0;

  // Sender pacing: beats go out in bursts, with a random idle gap bounded by max_gap between.
  int unsigned burst_left = 0;
  int unsigned max_gap    = 4;

  // Long output hold-off, requested by the stimulus and timed by the receiver.
  bit          hold_req    = 1'b0;
  int unsigned hold_cycles = 0;

  always #4 clk = ~clk;

  flow_to_bgr_pixel i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  flow_to_bgr_pixel_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stall in segments of random style. Style 0 never stalls, so
  // stretches of full rate occur; a pending hold-off request drops tready
  // in one piece, timed by hold_cycles.
  initial begin : receiver
    int unsigned span;
    int unsigned style;
    int unsigned k;
    forever begin
      span  = $urandom_range(16, 160);
      style = $urandom_range(0, 3);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_req) begin
          m_tready <= 1'b0;
          repeat (hold_cycles) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (k % 3 != 0);
          endcase
        end
      end
    end
  end

  // Offer one pixel and hold it until accepted. Entered and left at a
  // falling edge; tvalid stays high between beats of the same burst.
  task automatic send_pixel(input flow_t h, input flow_t v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, h};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // Drop tvalid and wait until every predicted pixel has come out.
  task automatic drain_pixels();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (pixels_in_flight != 0) @(negedge clk);
  endtask

  // One APB transfer: setup, access, then an idle spell with psel low so that
  // back-to-back transfers never touch psel twice in one step.
  task automatic apb_access(input bit write, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= GAIN_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write the gain and read it back; the checker compares the readback.
  task automatic set_gain(input gain_t g);
    apb_access(1'b1, {16'd0, g});
    apb_access(1'b0, '0);
  endtask

  function automatic gain_t gain_for_phase(input int unsigned phase);
    case (phase)
      0:       return GAIN_RESET;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3:       return gain_t'(256 * $urandom_range(1, 8));
      4, 8:    return gain_t'(32768 / $urandom_range(1, 127));  // 128 / bound in Q8.8
      5:       return gain_t'($urandom);
      6:       return 16'd256;
      7:       return 16'd128;
      default: return gain_t'($urandom_range(1, 4096));
    endcase
  endfunction

  // Mix full-range flow with values near the unsaturated band of the gain,
  // plus the corners.
  function automatic flow_t pick_flow(input gain_t g);
    int unsigned span;
    int          val;
    span = (g == 0) ? 32767 : (8388608 / g) + 64;
    if (span > 32767) span = 32767;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return flow_t'($urandom);
      9: begin
        case ($urandom_range(0, 4))
          0:       return -16'sd32768;
          1:       return -16'sd1;
          2:       return 16'sd0;
          3:       return 16'sd1;
          default: return 16'sd32767;
        endcase
      end
      default: begin
        val = int'($urandom_range(0, 2 * span)) - int'(span);
        return flow_t'(val);
      end
    endcase
  endfunction

  initial begin : stimulus
    gain_t       g;
    int unsigned phase;
    int unsigned n;

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset gain (6.0): readback, extremes, negative sum and overflow clamp.
    apb_access(1'b0, '0);
    send_pixel(16'sd0, 16'sd0);
    send_pixel(16'sd1, -16'sd1);
    send_pixel(16'sd32767, 16'sd32767);
    send_pixel(-16'sd32768, -16'sd32768);
    send_pixel(16'sd32767, -16'sd32768);
    send_pixel(-16'sd32768, 16'sd32767);
    send_pixel(-16'sd1, 16'sd0);
    send_pixel(16'sd5461, -16'sd5462);
    send_pixel(-16'sd5462, 16'sd0);
    drain_pixels();

    // Gain 1.0: exact halves on every channel, rounding to even both ways.
    set_gain(16'd256);
    send_pixel(16'sd128, 16'sd0);
    send_pixel(16'sd384, -16'sd128);
    send_pixel(-16'sd384, 16'sd128);
    send_pixel(16'sd0, 16'sd384);
    drain_pixels();

    // Zero gain: every channel sits at mid scale.
    set_gain(16'd0);
    send_pixel(-16'sd32768, 16'sd32767);
    send_pixel(16'sd12345, -16'sd1);
    drain_pixels();

    // Largest gain.
    set_gain(16'hFFFF);
    send_pixel(16'sd1, -16'sd1);
    send_pixel(16'sd0, 16'sd0);
    send_pixel(-16'sd32768, 16'sd1);
    drain_pixels();

    // Random phases, one gain each; the pipe is empty at every boundary.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      g = gain_for_phase(phase);
      set_gain(g);
      max_gap = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
      if (phase == 1) begin
        // Hold the output long enough for the pipe to fill and push back,
        // while the input keeps offering beats back to back.
        hold_cycles = 400;
        hold_req    = 1'b1;
        max_gap     = 0;
      end
      for (n = 0; n < PIXELS_PER_PHASE; n++) begin
        if (phase == 1 && n == 80) max_gap = 6;
        send_pixel(pick_flow(g), pick_flow(g));
      end
      drain_pixels();
    end

    // Let any stray beat surface before the verdict.
    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
